FILE: hw/rtl/stream_find_replace_top_macros.svh
// Assertion macros shared by the stream find/replace RTL.
// Depends on aclk and aresetn being visible in the using module.
`ifndef STREAM_FIND_REPLACE_TOP_MACROS_SVH
`define STREAM_FIND_REPLACE_TOP_MACROS_SVH

// Checked only out of reset.
`define SFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hw/rtl/sfr_pkg.sv
// Package for the stream find/replace block: widths and register indexes.
// No dependencies.
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_OUT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIND_PATTERN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_LENGTH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_PATTERN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH  = 4'd3;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

FILE: hw/rtl/stream_find_replace_top.sv
// Stream find/replace top level: window compare, result buffer, config registers.
// Depends on sfr_pkg and stream_find_replace_top_macros.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready    | s_text_byte, s_is_last
//  m_      | out | m_valid / m_ready    | m_out_byte, m_byte_valid, m_run_last,
//          |     |                      | m_stream_end, m_match_count, m_no_match
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// An input beat is fully evaluated in the cycle it is accepted; its results
// (0 to MAX_PATTERN_BYTES) land in a result buffer that drains one per cycle while
// m_ready is high, the first one offered in the cycle after the input beat.
// Throughput: one input beat per cycle while m_ready is high and each beat
// yields at most one result; a beat yielding more results keeps s_ready low.
// s_ready rises again in the cycle the buffer's last result is taken, so a
// low m_ready stalls input whenever the buffer holds a result.
// aresetn (synchronous, active low) clears buffer count, window fill,
// match counter and config registers to their reset values.
`include "stream_find_replace_top_macros.svh"

module stream_find_replace_top #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int COUNT_BITS        = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input text
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]        s_text_byte,
    input  logic                              s_is_last,
    // rewritten text
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sfr_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                              m_byte_valid,
    output logic                              m_run_last,
    output logic                              m_stream_end,
    output logic [sfr_pkg::COUNT_OUT_W-1:0]   m_match_count,
    output logic                              m_no_match,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int P      = MAX_PATTERN_BYTES;
    localparam int PAT_W  = P * sfr_pkg::BYTE_W;
    localparam int FILL_W = $clog2(P + 1);
    localparam logic [sfr_pkg::LEN_W-1:0] P_LEN = sfr_pkg::LEN_W'(P);

    // ---------------- configuration registers ----------------
    logic [PAT_W-1:0]              find_reg;
    logic [PAT_W-1:0]              repl_reg;
    logic [sfr_pkg::LEN_W-1:0]     find_len_reg;
    logic [sfr_pkg::LEN_W-1:0]     repl_len_reg;

    // ---------------- window state ----------------
    sfr_pkg::byte_t                win_reg [P];
    sfr_pkg::byte_t                win_next [P];
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [COUNT_BITS-1:0]         seen_reg, seen_next;

    // ---------------- result buffer ----------------
    sfr_pkg::byte_t                obuf_reg [P];
    sfr_pkg::byte_t                res [P];
    logic [FILL_W-1:0]             rem_reg, res_n;
    logic                          last_reg, bvalid_reg, nomatch_reg;
    logic [sfr_pkg::COUNT_OUT_W-1:0] cnt_reg, cnt_next;
    logic                          marker;

    logic                          in_beat, out_beat, cfg_beat;

    // ---------------- step datapath ----------------
    logic [FILL_W-1:0]             flen, rlen, f0, f1;
    sfr_pkg::byte_t                wtmp [P];
    logic                          full, hit;
    logic [31:0]                   seen_ext;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign m_valid   = (rem_reg != '0);
    assign out_beat  = m_valid && m_ready;
    assign s_ready   = (rem_reg == '0) || ((rem_reg == FILL_W'(1)) && m_ready);
    assign in_beat   = s_valid && s_ready;

    always_comb begin
        // clipped lengths
        if (find_len_reg == '0) begin
            flen = FILL_W'(1);
        end else if (find_len_reg > P_LEN) begin
            flen = FILL_W'(P);
        end else begin
            flen = FILL_W'(find_len_reg);
        end
        if (repl_len_reg > P_LEN) begin
            rlen = FILL_W'(P);
        end else begin
            rlen = FILL_W'(repl_len_reg);
        end

        f0 = (fill_reg >= flen) ? '0 : fill_reg;
        f1 = f0 + FILL_W'(1);
        for (int i = 0; i < P; i++) begin
            wtmp[i] = (FILL_W'(i) == f0) ? s_text_byte : win_reg[i];
        end

        full = (f1 == flen);
        hit  = full;
        for (int i = 0; i < P; i++) begin
            if ((FILL_W'(i) < flen) &&
                (wtmp[i] != find_reg[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])) begin
                hit = 1'b0;
            end
        end

        // window update; on a miss the oldest byte leaves
        for (int i = 0; i < P; i++) begin
            win_next[i] = wtmp[i];
        end
        if (full && !hit) begin
            for (int i = 0; i < P - 1; i++) begin
                win_next[i] = wtmp[i + 1];
            end
        end

        if (s_is_last || hit) begin
            fill_next = '0;
        end else if (full) begin
            fill_next = f1 - FILL_W'(1);
        end else begin
            fill_next = f1;
        end

        // results: replacement on a hit, else the window head (plus flush)
        for (int i = 0; i < P; i++) begin
            res[i] = hit ? repl_reg[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] : wtmp[i];
        end
        if (hit) begin
            res_n = rlen;
        end else if (s_is_last) begin
            res_n = f1;
        end else if (full) begin
            res_n = FILL_W'(1);
        end else begin
            res_n = '0;
        end
        marker = s_is_last && (res_n == '0);
        if (marker) begin
            res[0] = '0;
            res_n  = FILL_W'(1);
        end

        // saturating match counter
        seen_next = seen_reg;
        if (hit && (seen_reg != '1)) begin
            seen_next = seen_reg + COUNT_BITS'(1);
        end
        seen_ext = 32'(seen_next);
        cnt_next = (seen_ext > 32'hFFFF) ? 16'hFFFF : seen_ext[15:0];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= '0;
            fill_reg     <= '0;
            seen_reg     <= '0;
            find_len_reg <= sfr_pkg::LEN_W'(1);
            repl_len_reg <= '0;
            find_reg     <= '0;
            repl_reg     <= '0;
        end else begin
            if (in_beat) begin
                rem_reg  <= res_n;
                seen_reg <= s_is_last ? '0 : seen_next;
            end else if (out_beat) begin
                rem_reg <= rem_reg - FILL_W'(1);
            end
            // a new find length drops the buffered window bytes
            if (cfg_beat && (cfg_index == sfr_pkg::CFG_FIND_LENGTH)) begin
                fill_reg <= '0;
            end else if (in_beat) begin
                fill_reg <= fill_next;
            end
            if (cfg_beat) begin
                case (cfg_index)
                    sfr_pkg::CFG_FIND_PATTERN: begin
                        find_reg <= cfg_data[PAT_W-1:0];
                    end
                    sfr_pkg::CFG_FIND_LENGTH: begin
                        find_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                    end
                    sfr_pkg::CFG_REPLACE_PATTERN: begin
                        repl_reg <= cfg_data[PAT_W-1:0];
                    end
                    sfr_pkg::CFG_REPLACE_LENGTH: begin
                        repl_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload: window bytes and result buffer
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            for (int i = 0; i < P; i++) begin
                win_reg[i]  <= win_next[i];
                obuf_reg[i] <= res[i];
            end
            last_reg    <= s_is_last;
            bvalid_reg  <= !marker;
            cnt_reg     <= cnt_next;
            nomatch_reg <= s_is_last && (seen_next == '0);
        end else if (out_beat) begin
            for (int i = 0; i < P - 1; i++) begin
                obuf_reg[i] <= obuf_reg[i + 1];
            end
        end
    end

    assign m_out_byte    = obuf_reg[0];
    assign m_byte_valid  = bvalid_reg;
    assign m_run_last    = (rem_reg == FILL_W'(1));
    assign m_stream_end  = last_reg && m_run_last;
    assign m_match_count = cnt_reg;
    assign m_no_match    = nomatch_reg && m_run_last;

    // ---------------- assertions ----------------
    `SFR_ASSERT(a_last_empties, (in_beat && s_is_last) |=> (fill_reg == '0), "window not emptied at stream end")
    `SFR_ASSERT(a_buf_bound, in_beat |=> (rem_reg <= FILL_W'(P)), "result count exceeds buffer")
    `SFR_ASSERT(a_marker, (m_valid && !m_byte_valid) |-> (m_stream_end && (m_out_byte == '0)), "bad end marker")
    `SFR_ASSERT(a_drain, (out_beat && !in_beat) |=> (rem_reg == $past(rem_reg) - FILL_W'(1)), "buffer drain miscount")
    `SFR_ASSERT_ALWAYS(a_reset, !aresetn |=> ((rem_reg == '0) && (fill_reg == '0)), "reset left state")

endmodule

FILE: tb/tb_stream_find_replace_top.sv
// Self-checking testbench for stream_find_replace_top: byte stream in, rewritten stream out.
// Depends on sfr_pkg and the stream_find_replace_top RTL; holds its own rewrite predictor.
module tb_stream_find_replace_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 5;
    localparam int          MAX_BYTES     = 8;
    localparam int          COUNT_BITS    = 16;
    localparam int unsigned COUNT_LIMIT   = (1 << COUNT_BITS) - 1;
    localparam int          MAX_IDLE      = 11;
    localparam int          SETTLE_CYCLES = 10;    // block evaluates a beat in the cycle it is accepted
    localparam int          HOLD_CYCLES   = 200;   // long receiver stall

    // which registers a program_regs call writes, bit i = register index i
    localparam logic [3:0] SET_ALL      = 4'b1111;
    localparam logic [3:0] SET_FIND_LEN = 4'b0010;

    // one beat of the rewritten text
    typedef struct packed {
        sfr_pkg::byte_t                  out_byte;
        logic                            byte_valid;
        logic                            run_last;
        logic                            stream_end;
        logic [sfr_pkg::COUNT_OUT_W-1:0] match_count;
        logic                            no_match;
    } rewrite_t;

    // Scoreboard: mirrors the window, match counter and registers of the block,
    // turns every accepted text beat into the rewritten beats it should cause
    // and checks the output beats against them in order.
    class rewrite_scoreboard;
        sfr_pkg::byte_t win_q [MAX_BYTES];
        int unsigned    win_fill;
        int unsigned    match_tally;
        logic [63:0]    find_pat;
        logic [63:0]    rep_pat;
        logic [3:0]     find_len_cfg;
        logic [3:0]     rep_len_cfg;
        rewrite_t       rewritten_q [$];
        int unsigned    errors;

        function new();
            foreach (win_q[i]) win_q[i] = '0;
            win_fill     = 0;
            match_tally  = 0;
            find_pat     = '0;
            find_len_cfg = 4'd1;
            rep_pat      = '0;
            rep_len_cfg  = 4'd0;
            errors       = 0;
        endfunction

        function int unsigned pending();
            return rewritten_q.size();
        endfunction

        // effective find length: zero acts as one, anything above the max clips
        function int unsigned find_span();
            if (find_len_cfg == 0) return 1;
            if (find_len_cfg > MAX_BYTES) return MAX_BYTES;
            return find_len_cfg;
        endfunction

        function void write_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                logic [sfr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sfr_pkg::CFG_FIND_PATTERN:    find_pat = data;
                sfr_pkg::CFG_FIND_LENGTH: begin
                    find_len_cfg = data[3:0];
                    win_fill     = 0;    // buffered bytes are dropped, count kept
                end
                sfr_pkg::CFG_REPLACE_PATTERN: rep_pat = data;
                sfr_pkg::CFG_REPLACE_LENGTH:  rep_len_cfg = data[3:0];
                default: ;
            endcase
        endfunction

        function rewrite_t data_beat(sfr_pkg::byte_t v);
            rewrite_t r;
            r            = '0;
            r.out_byte   = v;
            r.byte_valid = 1'b1;
            return r;
        endfunction

        function void take_text_beat(sfr_pkg::byte_t b, logic last);
            int unsigned flen;
            int unsigned rlen;
            bit          hit;
            rewrite_t    run_q [$];
            rewrite_t    r;
            logic [15:0] shown;
            int unsigned n;
            flen = find_span();
            rlen = (rep_len_cfg > MAX_BYTES) ? MAX_BYTES : rep_len_cfg;
            if (win_fill >= flen) win_fill = 0;
            win_q[win_fill] = b;
            win_fill++;
            if (win_fill == flen) begin
                hit = 1'b1;
                for (int unsigned i = 0; i < flen; i++)
                    if (win_q[i] != find_pat[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    for (int unsigned i = 0; i < rlen; i++)
                        run_q.push_back(data_beat(rep_pat[8*i +: 8]));
                    if (match_tally < COUNT_LIMIT) match_tally++;
                    win_fill = 0;
                end else begin
                    run_q.push_back(data_beat(win_q[0]));
                    for (int unsigned i = 1; i < win_fill; i++) win_q[i-1] = win_q[i];
                    win_fill--;
                end
            end
            if (last) begin
                for (int unsigned i = 0; i < win_fill; i++) run_q.push_back(data_beat(win_q[i]));
                win_fill = 0;
                if (run_q.size() == 0) begin
                    r = '0;    // empty end marker
                    run_q.push_back(r);
                end
            end
            shown = (match_tally > 32'hFFFF) ? 16'hFFFF : 16'(match_tally);
            n     = run_q.size();
            for (int unsigned k = 0; k < n; k++) begin
                r             = run_q[k];
                r.match_count = shown;
                r.run_last    = (k == n - 1);
                r.stream_end  = last && (k == n - 1);
                r.no_match    = last && (k == n - 1) && (match_tally == 0);
                rewritten_q.push_back(r);
            end
            if (last) match_tally = 0;
        endfunction

        function void same_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_out_beat(rewrite_t got);
            rewrite_t want;
            if (rewritten_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected beat, expected none actual %h", $time, got);
                return;
            end
            want = rewritten_q.pop_front();
            same_field("out_byte",    16'(want.out_byte),   16'(got.out_byte));
            same_field("byte_valid",  16'(want.byte_valid), 16'(got.byte_valid));
            same_field("run_last",    16'(want.run_last),   16'(got.run_last));
            same_field("stream_end",  16'(want.stream_end), 16'(got.stream_end));
            same_field("match_count", want.match_count,     got.match_count);
            same_field("no_match",    16'(want.no_match),   16'(got.no_match));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    sfr_pkg::byte_t                  s_text_byte = '0;
    logic                            s_is_last   = 1'b0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    sfr_pkg::byte_t                  m_out_byte;
    logic                            m_byte_valid;
    logic                            m_run_last;
    logic                            m_stream_end;
    logic [sfr_pkg::COUNT_OUT_W-1:0] m_match_count;
    logic                            m_no_match;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;

    rewrite_scoreboard sb;

    // idle knobs: per-side random gaps on/off, plus a one-shot long receiver stall
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned rx_hold = 0;

    stream_find_replace_top #(
        .MAX_PATTERN_BYTES (MAX_BYTES),
        .COUNT_BITS        (COUNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_stream_end  (m_stream_end),
        .m_match_count (m_match_count),
        .m_no_match    (m_no_match),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Monitor: one process sees every handshake at the edge it completes.
    // All sampled values are pre-edge (drivers use NBAs), so there is no
    // race with the DUT or the driving tasks. A text beat is noted before
    // a result at the same edge, though a beat's results always come later.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.take_text_beat(s_text_byte, s_is_last);
            if (m_valid && m_ready)
                sb.check_out_beat('{m_out_byte, m_byte_valid, m_run_last,
                                    m_stream_end, m_match_count, m_no_match});
        end
    end

    // ------------------------------------------------------------------
    // Result sink: per beat, a random stall (or none when rx_idle is off),
    // then ready until a beat is taken. A pending rx_hold replaces one
    // draw with a long stall so the result buffer fills and the block
    // backs up its input. m_ready gets one NBA per time step.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold != 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offer one text beat after a random gap and hold it until taken.
    // s_valid stays high on return so back-to-back beats need no extra NBA.
    task automatic send_text(input sfr_pkg::byte_t b, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering, wait for every expected beat, then let the block settle.
    // The first edge lets the monitor log a beat accepted at the current one.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the registers picked by mask, back to back, valid held high between.
    task automatic program_regs(input logic [3:0] mask, input logic [63:0] fpat,
                                input logic [63:0] flen, input logic [63:0] rpat,
                                input logic [63:0] rlen);
        logic [sfr_pkg::CFG_DATA_W-1:0] val [4];
        logic [sfr_pkg::CFG_IDX_W-1:0]  idx [4];
        val = '{fpat, flen, rpat, rlen};
        idx = '{sfr_pkg::CFG_FIND_PATTERN, sfr_pkg::CFG_FIND_LENGTH,
                sfr_pkg::CFG_REPLACE_PATTERN, sfr_pkg::CFG_REPLACE_LENGTH};
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= idx[i];
                cfg_data  <= val[i];
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Random text built mostly from the current find pattern: whole occurrences,
    // cut-short or one-bit-corrupted ones, loose pattern bytes, and raw noise.
    task automatic rewrite_phase(input int unsigned n_items, input bit end_stream);
        sfr_pkg::byte_t pend_q [$];
        sfr_pkg::byte_t b;
        logic           last;
        int unsigned    flen;
        int unsigned    cut;
        int unsigned    pos;
        flen = sb.find_span();
        for (int unsigned k = 0; k < n_items; k++) begin
            if (pend_q.size() == 0) begin
                case ($urandom_range(0, 9)) inside
                    [0:4]: begin
                        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, flen) : flen;
                        for (int unsigned j = 0; j < cut; j++)
                            pend_q.push_back(sb.find_pat[8*j +: 8]);
                        if ($urandom_range(0, 5) == 0) begin
                            pos         = $urandom_range(0, cut - 1);
                            pend_q[pos] = pend_q[pos] ^
                                          sfr_pkg::byte_t'(1 << $urandom_range(0, 7));
                        end
                    end
                    [5:7]: pend_q.push_back(sb.find_pat[8*$urandom_range(0, flen - 1) +: 8]);
                    default: pend_q.push_back(sfr_pkg::byte_t'($urandom));
                endcase
            end
            b    = pend_q.pop_front();
            last = (end_stream && k == n_items - 1) || ($urandom_range(0, 19) == 0);
            send_text(b, last);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned n_items;
        int unsigned sel;
        int unsigned fl;
        logic [63:0] fl_word;
        logic [63:0] rl_word;
        logic [3:0]  mask;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset config: find one zero byte, replace with nothing.
        // Zero bytes match literally and vanish; a last beat whose match
        // leaves nothing gives the empty end marker; a stream without a
        // match raises no_match.
        send_text(8'h00, 1'b0);
        send_text(8'h41, 1'b0);
        send_text(8'h00, 1'b1);
        send_text(8'h41, 1'b1);
        drain_results();

        // "aba" -> eight-byte replacement; overlapping text keeps leftmost hits
        program_regs(SET_ALL, 64'h0000_0000_0061_6261, 64'd3,
                     64'hFFEE_DDCC_BBAA_9988, 64'd8);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h63, 1'b1);
        drain_results();

        // find length rewritten mid-stream: window dropped, match count kept
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        drain_results();
        program_regs(SET_FIND_LEN, '0, 64'd3, '0, '0);
        send_text(8'h61, 1'b1);
        drain_results();

        // find length zero acts as one; replace length above max clips to eight
        program_regs(SET_ALL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'h0, 64'd15);
        send_text(8'hFF, 1'b0);
        send_text(8'h7F, 1'b1);
        drain_results();

        // find length above max clips to eight: a full-width window match
        program_regs(SET_ALL, 64'h0123_4567_89AB_CDEF, 64'd15, 64'h80, 64'd1);
        send_text(8'hEF, 1'b0);
        send_text(8'hCD, 1'b0);
        send_text(8'hAB, 1'b0);
        send_text(8'h89, 1'b0);
        send_text(8'h67, 1'b0);
        send_text(8'h45, 1'b0);
        send_text(8'h23, 1'b0);
        send_text(8'h01, 1'b0);
        send_text(8'h55, 1'b1);
        drain_results();

        // Random phases. Each starts idle (sender paused until all results are
        // back); some only rewrite the find length, often mid-stream.
        for (int ph = 0; ph < 8; ph++) begin
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            sel     = $urandom_range(0, 9);
            if (sel < 6)      fl = $urandom_range(1, 4);
            else if (sel < 8) fl = $urandom_range(5, 8);
            else              fl = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
            fl_word      = {$urandom, $urandom};
            fl_word[3:0] = fl[3:0];
            rl_word      = {$urandom, $urandom};
            mask         = (ph % 3 == 2) ? SET_FIND_LEN : SET_ALL;
            program_regs(mask, {$urandom, $urandom}, fl_word, {$urandom, $urandom}, rl_word);
            if (ph == 3) begin
                // long receiver stall while the sender keeps pushing
                tx_idle = 1'b0;
                rx_hold = HOLD_CYCLES;
                n_items = 20;
            end else begin
                n_items = 10;
            end
            rewrite_phase(n_items, $urandom_range(0, 3) != 0);
            drain_results();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: several times the slowest legal run (about 120 beats, each
    // with up to eight results under the longest gaps, plus the long stall)
    initial begin : watchdog
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/stream_find_replace_top.sv
tb/tb_stream_find_replace_top.sv
